[rtl/core/sha256_stream_hasher_top_assert.svh]
// assertion macros for the sha-256 stream hasher checker
// depends on nothing; taken in by the checker file
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SHS_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("shs check failed");

// next-cycle implication, disabled in reset
`define SHS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("shs check failed");

// same-cycle implication, always checked
`define SHS_ASSERT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |-> (cons)) \
    else $error("shs check failed");

`endif

[rtl/core/shs_pkg.sv]
// shared types and constants of the sha-256 stream hasher
// depends on nothing
package shs_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } cmd_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

[rtl/core/shs_front.sv]
// input side: takes beats, turns them into commands, queues them
// depends on shs_pkg
module shs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          mode,
  input  logic [7:0]    data_byte,
  output logic          cmd_valid,
  output shs_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  shs_pkg::cmd_t q [shs_pkg::QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{finish: mode, data: data_byte};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

[rtl/core/shs_back.sv]
// execution side: byte packing, padding, 64-round compression, digest out
// depends on shs_pkg
module shs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  shs_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   digest_word,
  output logic [2:0]    word_index,
  output logic          last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RND  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_PAD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]   state;
  logic [31:0]  chain [8];
  logic [31:0]  r [8];
  logic [511:0] win;
  logic [5:0]   fill;
  logic [5:0]   rnd;
  logic [60:0]  len;
  logic [63:0]  bits;
  logic         fin;
  logic         sent80;
  logic [3:0]   lcnt;
  logic [2:0]   oidx;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] s0w, s1w, bs0, bs1, ch, mj, t1, t2;
  logic [7:0]  pad_byte;
  logic        is_len;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    w0    = win[511:480];
    w1    = win[479:448];
    w9    = win[223:192];
    w14   = win[63:32];
    s0w   = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1w   = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new = w0 + s0w + w9 + s1w;
    bs1   = rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25);
    ch    = (r[4] & r[5]) ^ (~r[4] & r[6]);
    t1    = r[7] + bs1 + ch + shs_pkg::K[rnd] + w0;
    bs0   = rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22);
    mj    = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
    t2    = bs0 + mj;
    // length bytes start once the block reaches byte 56
    is_len = sent80 && ((fill == 6'd56) || (lcnt != 4'd0));
    if (!sent80) begin
      pad_byte = 8'h80;
    end else if (is_len) begin
      pad_byte = bits[8'd63 - {lcnt[2:0], 3'b000} -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign cmd_pop     = (state == S_IDLE) && cmd_valid;
  assign out_valid   = (state == S_OUT);
  assign digest_word = chain[oidx];
  assign word_index  = oidx;
  assign last        = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= 6'd0;
      len    <= 61'd0;
      fin    <= 1'b0;
      sent80 <= 1'b0;
      lcnt   <= 4'd0;
      oidx   <= 3'd0;
      rnd    <= 6'd0;
      for (int j = 0; j < 8; j++) chain[j] <= shs_pkg::IV[j];
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (!cmd.finish) begin
              win  <= {win[503:0], cmd.data};
              fill <= fill + 6'd1;
              len  <= len + 61'd1;
              if (fill == 6'd63) begin
                state <= S_RND;
                rnd   <= 6'd0;
                for (int j = 0; j < 8; j++) r[j] <= chain[j];
              end
            end else begin
              bits   <= {len, 3'b000};
              fin    <= 1'b1;
              sent80 <= 1'b0;
              lcnt   <= 4'd0;
              state  <= S_PAD;
            end
          end
        end
        S_PAD: begin
          win    <= {win[503:0], pad_byte};
          fill   <= fill + 6'd1;
          sent80 <= 1'b1;
          if (is_len) lcnt <= lcnt + 4'd1;
          if (fill == 6'd63) begin
            state <= S_RND;
            rnd   <= 6'd0;
            for (int j = 0; j < 8; j++) r[j] <= chain[j];
          end
        end
        S_RND: begin
          win  <= {win[479:0], w_new};
          r[7] <= r[6];
          r[6] <= r[5];
          r[5] <= r[4];
          r[4] <= r[3] + t1;
          r[3] <= r[2];
          r[2] <= r[1];
          r[1] <= r[0];
          r[0] <= t1 + t2;
          rnd  <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int j = 0; j < 8; j++) chain[j] <= chain[j] + r[j];
          if (!fin) begin
            state <= S_IDLE;
          end else if (lcnt == 4'd8) begin
            state <= S_OUT;
            oidx  <= 3'd0;
          end else begin
            state <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int j = 0; j < 8; j++) chain[j] <= shs_pkg::IV[j];
              len   <= 61'd0;
              fill  <= 6'd0;
              fin   <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/sha256_stream_hasher_top.sv]
// top level of the sha-256 stream hasher: front queue plus compression back end
// depends on shs_pkg, shs_front, shs_back
//
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    mode, data_byte
// out      out  out_valid/out_ready  digest_word, word_index, last
//
// an absorb beat is packed into the block window by the back end; every 64th byte adds
// the 64 compression rounds (one round per cycle) plus the chaining additions
// a finish beat pads one byte per cycle, compresses one or two blocks,
// then shows the eight digest words, one per accepted output beat
// rst is synchronous; after it the chaining words hold the initial vector
// a two-entry command queue lets the input take up to two beats while the back end
// works or the output stalls
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last
);

  // queued command between the two halves
  shs_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  shs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .data_byte (data_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  shs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last        (last)
  );

endmodule

[rtl/core/shs_checker.sv]
// port-level checks of the sha-256 stream hasher, bound to the top level
// depends on sha256_stream_hasher_top_assert.svh
`include "sha256_stream_hasher_top_assert.svh"

module shs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last
);

  `SHS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index))
  `SHS_ASSERT_NOW(a_last_idx, clk, rst, out_valid, last == (word_index == 3'd7))
  `SHS_ASSERT_NEXT(a_idx_step, clk, rst, out_valid && out_ready && !last, out_valid && (word_index == $past(word_index) + 3'd1))
  `SHS_ASSERT_ALWAYS(a_rst_quiet, clk, $past(rst), !out_valid)

endmodule

bind sha256_stream_hasher_top shs_checker u_shs_checker (.*);

[verif/sha256_stream_hasher_top_tb.sv]
// self-checking testbench for the sha-256 stream hasher top level
// depends on shs_pkg and sha256_stream_hasher_top; holds its own digest predictor
`timescale 1ns / 1ps

module sha256_stream_hasher_top_tb;

  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_beat_t;

  // one directed row: a beat, plus the typed-in first digest word where it is known at a glance
  typedef struct {
    logic        fin;
    logic [7:0]  data;
    logic        known;
    logic [31:0] known_word0;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  sha256_stream_hasher_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last(last)
  );

  // predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  logic [5:0]  block_fill;
  logic [60:0] byte_count;

  digest_beat_t pending_digest [$];
  int unsigned  mismatch_count;
  int unsigned  digest_count;
  int unsigned  beat_count;
  int unsigned  cycle_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_off_cycles;

  function automatic logic [31:0] ror(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
           + w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
    {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
         + shs_pkg::K[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic load_byte(logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill = block_fill + 6'd1;
    if (block_fill == 6'd0) compress_block();
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = shs_pkg::IV[i];
    block_fill = 6'd0;
    byte_count = 61'd0;
  endtask

  // model one accepted beat; a finish queues the eight digest words
  task automatic predict_beat(logic fin, logic [7:0] b);
    logic [63:0] bit_len;
    digest_beat_t e;
    if (!fin) begin
      load_byte(b);
      byte_count = byte_count + 61'd1;
      return;
    end
    bit_len = {byte_count, 3'b000};
    load_byte(8'h80);
    while (block_fill != 6'd56) load_byte(8'h00);
    for (int i = 0; i < 8; i++) load_byte(bit_len[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      e.word = hash_state[i];
      e.idx  = i[2:0];
      e.fin  = (i == 7);
      pending_digest.push_back(e);
    end
    digest_count++;
    restart_hash();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d digest words outstanding", pending_digest.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // output side: compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    digest_beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_digest.size() == 0) begin
        report_mismatch("unexpected digest beat", digest_word, 32'h0);
      end else begin
        e = pending_digest.pop_front();
        if (digest_word !== e.word) report_mismatch("digest_word", digest_word, e.word);
        if (word_index !== e.idx)
          report_mismatch("word_index", 32'(word_index), 32'(e.idx));
        if (last !== e.fin) report_mismatch("last", 32'(last), 32'(e.fin));
      end
    end
  end

  // receiver: random stalls, or a long hold-off counted here
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // present one beat and hold it until accepted; returns at the next falling edge
  task automatic send_beat(logic fin, logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= fin;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(fin, b);
    beat_count++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_digest.size() != 0) @(negedge clk);
  endtask

  // a short message of random length
  task automatic random_message();
    int unsigned len;
    len = $urandom_range(3);
    for (int i = 0; i < len; i++) send_beat(1'b0, 8'($urandom_range(255)));
    send_beat(1'b1, 8'($urandom_range(255)));
  endtask

  stim_row_t directed [$];
  int unsigned phase_idle [4] = '{0, 87, 0, 37};
  int unsigned phase_stall [4] = '{0, 0, 87, 37};

  initial begin
    mismatch_count = 0; digest_count = 0; beat_count = 0; cycle_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
    in_valid = 1'b0; mode = 1'b0; data_byte = 8'h00; out_ready = 1'b0;
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    restart_hash();
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty message right after reset, with a nonzero ignored byte
    directed.push_back('{1'b1, 8'hff, 1'b1, 32'he3b0c442});
    // "abc"
    directed.push_back('{1'b0, 8'h61, 1'b0, 32'h0});
    directed.push_back('{1'b0, 8'h62, 1'b0, 32'h0});
    directed.push_back('{1'b0, 8'h63, 1'b0, 32'h0});
    directed.push_back('{1'b1, 8'h00, 1'b1, 32'hba7816bf});
    // byte extremes and all bit toggles
    directed.push_back('{1'b0, 8'h00, 1'b0, 32'h0});
    directed.push_back('{1'b0, 8'hff, 1'b0, 32'h0});
    directed.push_back('{1'b0, 8'haa, 1'b0, 32'h0});
    directed.push_back('{1'b0, 8'h55, 1'b0, 32'h0});
    directed.push_back('{1'b1, 8'h5a, 1'b0, 32'h0});
    // two empty messages in a row, each sent after the output has drained
    directed.push_back('{1'b1, 8'h00, 1'b1, 32'he3b0c442});
    directed.push_back('{1'b1, 8'h80, 1'b1, 32'he3b0c442});

    foreach (directed[i]) begin
      if (directed[i].known) begin
        wait_drain();
        send_beat(directed[i].fin, directed[i].data);
        if (pending_digest[0].word !== directed[i].known_word0)
          report_mismatch("predicted word 0", pending_digest[0].word,
                          directed[i].known_word0);
      end else begin
        send_beat(directed[i].fin, directed[i].data);
      end
    end
    // a 56-byte message puts the 0x80 at byte 56 and needs a second padding block
    for (int i = 0; i < 56; i++) send_beat(1'b0, 8'($urandom_range(255)));
    send_beat(1'b1, 8'h00);
    wait_drain();

    // random part in idling phases
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      repeat (2) random_message();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // long receiver hold-off while several finish beats pile up
    hold_off_cycles = 600;
    repeat (5) send_beat(1'b1, 8'($urandom_range(255)));
    // sender pauses until everything has come out
    wait_drain();
    repeat (2) random_message();

    wait_drain();
    repeat (200) @(negedge clk);
    $display("covered %0d input beats and %0d digests, empty to two-block padded messages",
             beat_count, digest_count);
    $display("idling phases none, sender 87, receiver 87, both 37, plus a long hold-off");
    if (mismatch_count == 0 && pending_digest.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
